### rtl/phsv_pkg.sv
package phsv_pkg;

    localparam int unsigned PipeDepth = 7;

    localparam logic [5:0]  AlphaFull   = 6'd32;
    localparam logic [5:0]  SixBitMax   = 6'h3f;
    localparam logic [11:0] HueMod      = 12'd360;
    localparam logic [10:0] HueScale    = 11'h7ff;
    localparam logic [10:0] RegionSpan  = 11'd341;
    localparam logic [16:0] FracOne     = 17'h1ffff;

    // floor(x / 360) by reciprocal multiply; exact over the ranges used
    localparam logic [23:0] HueRecip    = 24'd2913;     // 2^20 / 360, rounded up
    localparam logic [39:0] ScaleRecip  = 40'd745655;   // 2^28 / 360, rounded up

    typedef enum logic [2:0] {
        HUE_R0 = 3'd0,
        HUE_R1 = 3'd1,
        HUE_R2 = 3'd2,
        HUE_R3 = 3'd3,
        HUE_R4 = 3'd4,
        HUE_R5 = 3'd5
    } region_t;

    typedef struct packed {
        logic        hsv;
        logic        gray;
        logic [5:0]  sat;
        logic [7:0]  val;
        logic [7:0]  opacity;
        logic [23:0] pix;
    } ctx_t;

endpackage

### rtl/phsv_datapath.sv
module phsv_datapath (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] color_word,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  opacity,
    output logic [15:0] rgb565
);
    import phsv_pkg::*;

    // stage 1: decode, value scale, opacity, coarse hue quotient
    logic [5:0]  code;
    logic [5:0]  code_sat;
    logic [13:0] opa_prod;
    logic [5:0]  v6;
    logic [1:0]  v_div21;
    logic [23:0] hue_prod;
    ctx_t        c1_next;
    ctx_t        c1_reg;
    logic [11:0] hue1_reg;
    logic [3:0]  hq1_reg;

    always_comb
    begin
        code     = color_word[29:24];
        code_sat = (code > AlphaFull) ? AlphaFull : code;
        opa_prod = 14'(AlphaFull - code_sat) * 14'd255;
        v6       = color_word[5:0];
        if (v6 >= 6'd63)
            v_div21 = 2'd3;
        else if (v6 >= 6'd42)
            v_div21 = 2'd2;
        else if (v6 >= 6'd21)
            v_div21 = 2'd1;
        else
            v_div21 = 2'd0;
        hue_prod = 24'(color_word[23:12]) * HueRecip;

        c1_next.hsv     = color_word[30];
        c1_next.gray    = (color_word[11:6] == 6'd0);
        c1_next.sat     = color_word[11:6];
        c1_next.val     = {v6, 2'b00} + 8'(v_div21);   // (v * 255) / 63
        c1_next.opacity = opa_prod[12:5];
        c1_next.pix     = color_word[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= c1_next;
            hue1_reg <= color_word[23:12];
            hq1_reg  <= hue_prod[23:20];
        end
    end

    // stage 2: hue mod 360, times 2047
    logic [11:0] hue_mod_full;
    logic [8:0]  hue_mod;
    logic [19:0] x2_next;
    ctx_t        c2_reg;
    logic [19:0] x2_reg;

    always_comb
    begin
        hue_mod_full = hue1_reg - 12'(hq1_reg) * HueMod;
        hue_mod      = hue_mod_full[8:0];
        x2_next      = {hue_mod, 11'b0} - 20'(hue_mod);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg <= c1_reg;
            x2_reg <= x2_next;
        end
    end

    // stage 3: scaled hue = x / 360
    logic [39:0] hs_prod;
    ctx_t        c3_reg;
    logic [10:0] hs3_reg;

    assign hs_prod = 40'(x2_reg) * ScaleRecip;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg  <= c2_reg;
            hs3_reg <= hs_prod[38:28];
        end
    end

    // stage 4: region and remainder
    region_t     region_next;
    logic [10:0] base;
    logic [10:0] diff;
    logic [10:0] rem_next;
    ctx_t        c4_reg;
    region_t     region4_reg;
    logic [10:0] rem4_reg;

    always_comb
    begin
        if (hs3_reg >= 11'd1705)
        begin
            region_next = HUE_R5;
            base        = 11'd1705;
        end
        else if (hs3_reg >= 11'd1364)
        begin
            region_next = HUE_R4;
            base        = 11'd1364;
        end
        else if (hs3_reg >= 11'd1023)
        begin
            region_next = HUE_R3;
            base        = 11'd1023;
        end
        else if (hs3_reg >= 11'd682)
        begin
            region_next = HUE_R2;
            base        = 11'd682;
        end
        else if (hs3_reg >= RegionSpan)
        begin
            region_next = HUE_R1;
            base        = RegionSpan;
        end
        else
        begin
            region_next = HUE_R0;
            base        = 11'd0;
        end
        diff     = hs3_reg - base;
        rem_next = {diff[8:0], 2'b00} + {1'b0, diff[8:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4_reg      <= c3_reg;
            region4_reg <= region_next;
            rem4_reg    <= rem_next;
        end
    end

    // stage 5: saturation products and p
    logic [16:0] ta_next;
    logic [16:0] qa_next;
    logic [13:0] p_prod;
    ctx_t        c5_reg;
    region_t     region5_reg;
    logic [16:0] ta5_reg;
    logic [16:0] qa5_reg;
    logic [7:0]  p5_reg;

    always_comb
    begin
        ta_next = 17'(c4_reg.sat) * 17'(HueScale - rem4_reg);
        qa_next = 17'(c4_reg.sat) * 17'(rem4_reg);
        p_prod  = 14'(c4_reg.val) * 14'(SixBitMax - c4_reg.sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c5_reg      <= c4_reg;
            region5_reg <= region4_reg;
            ta5_reg     <= ta_next;
            qa5_reg     <= qa_next;
            p5_reg      <= p_prod[13:6];
        end
    end

    // stage 6: t and q
    logic [24:0] t_prod;
    logic [24:0] q_prod;
    ctx_t        c6_reg;
    region_t     region6_reg;
    logic [7:0]  p6_reg;
    logic [7:0]  t6_reg;
    logic [7:0]  q6_reg;

    always_comb
    begin
        t_prod = 25'(c5_reg.val) * 25'(FracOne - ta5_reg);
        q_prod = 25'(c5_reg.val) * 25'(FracOne - qa5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c6_reg      <= c5_reg;
            region6_reg <= region5_reg;
            p6_reg      <= p5_reg;
            t6_reg      <= t_prod[24:17];
            q6_reg      <= q_prod[24:17];
        end
    end

    // stage 7: channel select and pack
    logic [7:0] r_next;
    logic [7:0] g_next;
    logic [7:0] b_next;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] opacity_reg;
    logic [15:0] rgb565_reg;

    always_comb
    begin
        if (!c6_reg.hsv)
        begin
            r_next = c6_reg.pix[23:16];
            g_next = c6_reg.pix[15:8];
            b_next = c6_reg.pix[7:0];
        end
        else if (c6_reg.gray)
        begin
            r_next = c6_reg.val;
            g_next = c6_reg.val;
            b_next = c6_reg.val;
        end
        else
        begin
            case (region6_reg)
                HUE_R0:
                begin
                    r_next = c6_reg.val; g_next = t6_reg;     b_next = p6_reg;
                end
                HUE_R1:
                begin
                    r_next = q6_reg;     g_next = c6_reg.val; b_next = p6_reg;
                end
                HUE_R2:
                begin
                    r_next = p6_reg;     g_next = c6_reg.val; b_next = t6_reg;
                end
                HUE_R3:
                begin
                    r_next = p6_reg;     g_next = q6_reg;     b_next = c6_reg.val;
                end
                HUE_R4:
                begin
                    r_next = t6_reg;     g_next = p6_reg;     b_next = c6_reg.val;
                end
                default:
                begin
                    r_next = c6_reg.val; g_next = p6_reg;     b_next = q6_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg     <= r_next;
            green_reg   <= g_next;
            blue_reg    <= b_next;
            opacity_reg <= c6_reg.opacity;
            rgb565_reg  <= {r_next[7:3], g_next[7:2], b_next[7:3]};
        end
    end

    assign red     = red_reg;
    assign green   = green_reg;
    assign blue    = blue_reg;
    assign opacity = opacity_reg;
    assign rgb565  = rgb565_reg;

endmodule

### rtl/packed_hsv_to_rgb_converter_top.sv
// Packed color word to RGB converter. Each transaction on the color channel
// carries one 32-bit word: bit 30 selects HSV (hue 23:12, saturation 11:6,
// value 5:0) or RGB888, bits 29:24 a transparency code (codes above 32 act
// as 32). Each word yields one transaction on the result channel with 8-bit
// red, green, blue, an RGB565 pack and an 8-bit opacity. The datapath is a
// seven-stage pipeline, and one word per cycle is accepted for as long as
// results are taken; the whole pipeline holds while a finished result waits
// on rgb_ready.
module packed_hsv_to_rgb_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        color_valid,
    output logic        color_ready,
    input  logic [31:0] color_word,
    output logic        rgb_valid,
    input  logic        rgb_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  opacity,
    output logic [15:0] rgb565
);
    import phsv_pkg::*;

    logic                 en;
    logic [PipeDepth-1:0] valid_reg;
    logic [PipeDepth-1:0] valid_next;

    assign en         = !valid_reg[PipeDepth-1] || rgb_ready;
    assign valid_next = {valid_reg[PipeDepth-2:0], color_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    assign color_ready = en;
    assign rgb_valid   = valid_reg[PipeDepth-1];

    phsv_datapath u_datapath (
        .clk        (clk),
        .en         (en),
        .color_word (color_word),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .opacity    (opacity),
        .rgb565     (rgb565)
    );

endmodule
